// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tint_pkg.sv -----
// Types, codes and constants of the table interpolator.
package tint_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 256;
  localparam int MIN_POINTS          = 2;
  localparam int SIZE_W              = 9;
  localparam int VAL_W               = 32;
  localparam int PROD_W              = 2 * VAL_W;
  localparam int SEG_W               = 8;
  localparam int IDX_W               = 8;
  localparam int PADDR_W             = 3;
  localparam int PDATA_W             = 32;

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = SIZE_W'(2);

  // register indexes (paddr[2])
  localparam logic REG_TABLE_SIZE  = 1'b0;
  localparam logic REG_INTERP_MODE = 1'b1;

  // op codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // interp_mode codes
  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_STEP   = 1'b1;

  // status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_SIZE_ERR  = 2'd1;
  localparam logic [1:0] STATUS_SATURATED = 2'd2;

  localparam logic signed [VAL_W-1:0] Y_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] Y_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                    op;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] x_value;
    logic signed [VAL_W-1:0] y_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] y_result;
    logic [SEG_W-1:0]        segment;
    logic [1:0]              status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_RD_LAST,
    ST_SEARCH,
    ST_CMP,
    ST_RD_LEFT,
    ST_RD_RIGHT,
    ST_SETUP,
    ST_MAG,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV,
    ST_ROUND,
    ST_SAT,
    ST_OUT
  } state_t;

endpackage

// ----- rtl/tint_ram.sv -----
// Generic simple dual-port RAM with registered read.
module tint_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/tint_div.sv -----
// Restoring divider, one quotient bit per cycle.
module tint_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tint_pkg::PROD_W-1:0]  dividend,
  input  logic [tint_pkg::VAL_W-1:0]   divisor,
  output logic [tint_pkg::PROD_W-1:0]  quotient,
  output logic [tint_pkg::VAL_W-1:0]   remainder,
  output logic                         done
);
  import tint_pkg::*;

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] quo_r;
  logic [VAL_W-1:0]  rem_r;
  logic [VAL_W-1:0]  dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [VAL_W:0]    rem_sh;
  logic [VAL_W:0]    rem_diff;
  logic              ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[PROD_W-1]};
    ge       = rem_sh >= {1'b0, dvs_r};
    rem_diff = rem_sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(PROD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? rem_diff[VAL_W-1:0] : rem_sh[VAL_W-1:0];
      quo_r <= {quo_r[PROD_W-2:0], ge};
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

// ----- rtl/table_interpolator.sv -----
// Piecewise-linear breakpoint table interpolator, top level.
//
// Breakpoint x and y live in two RAMs of TABLE_DEPTH entries (registered
// read). A write item stores one entry and returns its zero result in the
// cycle after acceptance. A query searches by bisection, reading one x entry
// in ST_SEARCH and comparing it in ST_CMP at each step, then reads the
// segment ends, forms (x - x0) * (y1 - y0) with one 32x32 multiply and
// divides by (x1 - x0) in a 64-step restoring divider. Step mode and equal
// segment x skip the multiply and divide and return the left y. A size
// error skips the search and goes straight to the output state. One item is
// in work at a time; a result waits in the output register while the next
// query is already accepted.
// Entries must be written before a query reads them.
module table_interpolator #(
  parameter int TABLE_DEPTH = tint_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  tint_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output tint_pkg::out_item_t          out_data,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [tint_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [tint_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [tint_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                         cfg_pready
);
  import tint_pkg::*;

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int NW   = $clog2(TABLE_DEPTH + 1);
  localparam int CW   = (NW > SIZE_W) ? NW : SIZE_W;
  localparam int IXW  = ((AW + 1) > (IDX_W + 1)) ? (AW + 1) : (IDX_W + 1);
  localparam int DW   = VAL_W + 1;
  localparam int SW   = VAL_W + 3;

  localparam logic signed [SW-1:0] SUM_MAX = 35'sh0_7FFF_FFFF;
  localparam logic signed [SW-1:0] SUM_MIN = 35'sh7_8000_0000;
  localparam logic [PROD_W-1:0]    Q_LIMIT = PROD_W'(64'h2_0000_0000);

  // configuration registers
  logic [SIZE_W-1:0] cfg_size_r;
  logic              cfg_mode_r;
  logic              cfg_wr;
  logic              reg_idx;

  assign reg_idx    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_size_r <= TABLE_SIZE_RESET;
      cfg_mode_r <= MODE_LINEAR;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_TABLE_SIZE:  cfg_size_r <= cfg_pwdata[SIZE_W-1:0];
        REG_INTERP_MODE: cfg_mode_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TABLE_SIZE:  cfg_prdata = PDATA_W'(cfg_size_r);
      REG_INTERP_MODE: cfg_prdata = PDATA_W'(cfg_mode_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // control and datapath registers
  state_t                  state_r, state_nxt;
  logic signed [VAL_W-1:0] x_q_r, x_q_nxt;
  logic [AW-1:0]           last_r, last_nxt;
  logic [AW-1:0]           lo_r, lo_nxt;
  logic [AW-1:0]           hi_r, hi_nxt;
  logic [AW-1:0]           mid_r, mid_nxt;
  logic                    asc_r, asc_nxt;
  logic signed [VAL_W-1:0] x_first_r, x_first_nxt;
  logic signed [VAL_W-1:0] x0_r, x0_nxt;
  logic signed [VAL_W-1:0] y0_r, y0_nxt;
  logic signed [VAL_W-1:0] x1_r, x1_nxt;
  logic signed [VAL_W-1:0] y1_r, y1_nxt;
  logic signed [DW-1:0]    dxq_r, dxq_nxt;
  logic signed [DW-1:0]    dy_r, dy_nxt;
  logic signed [DW-1:0]    dx_r, dx_nxt;
  logic [VAL_W-1:0]        amag_r, amag_nxt;
  logic [VAL_W-1:0]        bmag_r, bmag_nxt;
  logic [VAL_W-1:0]        dmag_r, dmag_nxt;
  logic                    neg_r, neg_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic [PROD_W-1:0]       qr_r, qr_nxt;
  logic signed [VAL_W-1:0] res_y_r, res_y_nxt;
  logic [1:0]              res_st_r, res_st_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;

  // memories
  logic              x_we;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [VAL_W-1:0]  x_rdata;
  logic [VAL_W-1:0]  y_rdata;

  // divider
  logic              div_start;
  logic [PROD_W-1:0] div_quo;
  logic [VAL_W-1:0]  div_rem;
  logic              div_done;

  // helpers
  logic              in_acc;
  logic              out_free;
  logic [IXW-1:0]    idx_ext;
  logic              idx_in_range;
  logic [CW-1:0]     size_ext;
  logic [CW-1:0]     n_use;
  logic [CW-1:0]     n_last;
  logic [AW:0]       mid_sum;
  logic [AW-1:0]     span;
  logic signed [SW-1:0] q35;
  logic signed [SW-1:0] sum_c;
  logic              round_up;

  assign out_free     = !out_valid_r || !out_stall;
  assign in_stall     = (state_r != ST_IDLE) || (in_data.op == OP_WRITE && !out_free);
  assign in_acc       = in_valid && !in_stall;
  assign idx_ext      = IXW'(in_data.entry_index);
  assign idx_in_range = idx_ext < IXW'(TABLE_DEPTH);
  assign wr_addr      = idx_ext[AW-1:0];
  assign x_we         = in_acc && in_data.op == OP_WRITE && idx_in_range;
  assign size_ext     = CW'(cfg_size_r);
  assign n_use        = (size_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : size_ext;
  assign n_last       = n_use - CW'(1);
  assign mid_sum      = {1'b0, lo_r} + {1'b0, hi_r};
  assign span         = hi_r - lo_r;
  assign div_start    = (state_r == ST_DIV_GO);
  assign round_up     = {div_rem, 1'b0} >= {1'b0, dmag_r};
  assign q35          = $signed({1'b0, qr_r[SW-2:0]});
  assign sum_c        = $signed({{3{y0_r[VAL_W-1]}}, y0_r}) + (neg_r ? -q35 : q35);

  tint_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_x_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (wr_addr),
    .wdata (in_data.x_value),
    .raddr (rd_addr),
    .rdata (x_rdata)
  );

  tint_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_y_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (wr_addr),
    .wdata (in_data.y_value),
    .raddr (rd_addr),
    .rdata (y_rdata)
  );

  tint_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (prod_r),
    .divisor   (dmag_r),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  always_comb begin
    state_nxt     = state_r;
    x_q_nxt       = x_q_r;
    last_nxt      = last_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    asc_nxt       = asc_r;
    x_first_nxt   = x_first_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    dxq_nxt       = dxq_r;
    dy_nxt        = dy_r;
    dx_nxt        = dx_r;
    amag_nxt      = amag_r;
    bmag_nxt      = bmag_r;
    dmag_nxt      = dmag_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    qr_nxt        = qr_r;
    res_y_nxt     = res_y_r;
    res_st_nxt    = res_st_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_addr       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.op == OP_WRITE) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{y_result: '0, segment: '0, status: STATUS_OK};
          end else begin
            x_q_nxt  = in_data.x_value;
            lo_nxt   = '0;
            last_nxt = n_last[AW-1:0];
            if (n_use < CW'(MIN_POINTS)) begin
              res_y_nxt  = '0;
              res_st_nxt = STATUS_SIZE_ERR;
              state_nxt  = ST_OUT;
            end else begin
              // first entry is read at this edge
              state_nxt = ST_RD_FIRST;
            end
          end
        end
      end
      ST_RD_FIRST: begin
        x_first_nxt = $signed(x_rdata);
        rd_addr     = last_r;
        state_nxt   = ST_RD_LAST;
      end
      ST_RD_LAST: begin
        asc_nxt   = $signed(x_rdata) >= x_first_r;
        lo_nxt    = '0;
        hi_nxt    = last_r;
        state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (span > AW'(1)) begin
          mid_nxt   = mid_sum[AW:1];
          rd_addr   = mid_sum[AW:1];
          state_nxt = ST_CMP;
        end else begin
          rd_addr   = lo_r;
          state_nxt = ST_RD_LEFT;
        end
      end
      ST_CMP: begin
        if ((x_q_r >= $signed(x_rdata)) == asc_r) begin
          lo_nxt = mid_r;
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = ST_SEARCH;
      end
      ST_RD_LEFT: begin
        x0_nxt    = $signed(x_rdata);
        y0_nxt    = $signed(y_rdata);
        rd_addr   = lo_r + AW'(1);
        state_nxt = ST_RD_RIGHT;
      end
      ST_RD_RIGHT: begin
        x1_nxt = $signed(x_rdata);
        y1_nxt = $signed(y_rdata);
        if (cfg_mode_r == MODE_STEP || x0_r == $signed(x_rdata)) begin
          res_y_nxt  = y0_r;
          res_st_nxt = STATUS_OK;
          state_nxt  = ST_OUT;
        end else begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        dxq_nxt   = $signed({x_q_r[VAL_W-1], x_q_r}) - $signed({x0_r[VAL_W-1], x0_r});
        dy_nxt    = $signed({y1_r[VAL_W-1], y1_r}) - $signed({y0_r[VAL_W-1], y0_r});
        dx_nxt    = $signed({x1_r[VAL_W-1], x1_r}) - $signed({x0_r[VAL_W-1], x0_r});
        state_nxt = ST_MAG;
      end
      ST_MAG: begin
        amag_nxt  = dxq_r[DW-1] ? VAL_W'(-dxq_r) : VAL_W'(dxq_r);
        bmag_nxt  = dy_r[DW-1]  ? VAL_W'(-dy_r)  : VAL_W'(dy_r);
        dmag_nxt  = dx_r[DW-1]  ? VAL_W'(-dx_r)  : VAL_W'(dx_r);
        // a zero factor leaves the sign positive
        neg_nxt   = (dxq_r[DW-1] ^ dy_r[DW-1] ^ dx_r[DW-1]) &&
                    (dxq_r != '0) && (dy_r != '0);
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = amag_r * bmag_r;
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        // round half away from zero on the magnitude
        qr_nxt    = div_quo + PROD_W'(round_up);
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        if (qr_r > Q_LIMIT) begin
          res_y_nxt  = neg_r ? Y_MIN : Y_MAX;
          res_st_nxt = STATUS_SATURATED;
        end else if (sum_c > SUM_MAX) begin
          res_y_nxt  = Y_MAX;
          res_st_nxt = STATUS_SATURATED;
        end else if (sum_c < SUM_MIN) begin
          res_y_nxt  = Y_MIN;
          res_st_nxt = STATUS_SATURATED;
        end else begin
          res_y_nxt  = sum_c[VAL_W-1:0];
          res_st_nxt = STATUS_OK;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{y_result: res_y_r, segment: SEG_W'(lo_r), status: res_st_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_q_r      <= x_q_nxt;
    last_r     <= last_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    asc_r      <= asc_nxt;
    x_first_r  <= x_first_nxt;
    x0_r       <= x0_nxt;
    y0_r       <= y0_nxt;
    x1_r       <= x1_nxt;
    y1_r       <= y1_nxt;
    dxq_r      <= dxq_nxt;
    dy_r       <= dy_nxt;
    dx_r       <= dx_nxt;
    amag_r     <= amag_nxt;
    bmag_r     <= bmag_nxt;
    dmag_r     <= dmag_nxt;
    neg_r      <= neg_nxt;
    prod_r     <= prod_nxt;
    qr_r       <= qr_nxt;
    res_y_r    <= res_y_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/tint_chk.sv -----
// Port-level assertions of the table interpolator, bound to the top level.
`include "assert_macros.svh"

module tint_chk (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  tint_pkg::in_item_t           in_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  tint_pkg::out_item_t          out_data
);
  import tint_pkg::*;

  logic in_acc;
  logic out_hold;

  assign in_acc   = in_valid && !in_stall;
  assign out_hold = out_valid && out_stall;

  // a result beat held by the sink stays put
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_hold, out_valid && $stable(out_data), "result beat changed while stalled")

  // a write produces its zero result on the next cycle
  `ASSERT_NEXT(a_write_result, clk, rst_n, in_acc && in_data.op == OP_WRITE, out_valid && out_data.y_result == '0 && out_data.segment == '0 && out_data.status == STATUS_OK, "write result missing or wrong")

  // a query keeps the input side busy on the next cycle
  `ASSERT_NEXT(a_query_busy, clk, rst_n, in_acc && in_data.op == OP_QUERY, in_stall, "input accepted during a query")

  // size errors carry a zero payload
  `ASSERT_IMPL(a_size_err, clk, rst_n, out_valid && out_data.status == STATUS_SIZE_ERR, out_data.y_result == '0 && out_data.segment == '0, "size error with nonzero payload")

  // saturated results sit on a rail
  `ASSERT_IMPL(a_sat_rail, clk, rst_n, out_valid && out_data.status == STATUS_SATURATED, out_data.y_result == Y_MAX || out_data.y_result == Y_MIN, "saturated result off the rails")

endmodule

bind table_interpolator tint_chk u_tint_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- bench/testbench.sv -----
// Self-checking bench for table_interpolator: breakpoint table predictor, scoreboard, traffic.
module testbench;
  import tint_pkg::*;

  localparam int DEPTH       = DEFAULT_TABLE_DEPTH;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 5000;
  localparam int MAX_REPORTS = 60;
  localparam int RANDOM_ITEMS = 1800;

  // Shadow of the breakpoint table and registers; predicts one answer per beat.
  class table_tracker;
    int               bp_x[DEPTH];
    int               bp_y[DEPTH];
    bit [SIZE_W-1:0]  size_reg = TABLE_SIZE_RESET;
    bit               mode_reg = MODE_LINEAR;
    out_item_t        answers_due[$];
    int               results_seen;
    int               mismatches;

    function void set_reg(logic idx, logic [31:0] value);
      if (idx == REG_TABLE_SIZE) size_reg = value[SIZE_W-1:0];
      else mode_reg = value[0];
    endfunction

    function longint unsigned magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function void accept_item(in_item_t it);
      out_item_t ans;
      int n, lo, hi, mid, j, xq, x0, x1, y0, y1;
      bit rising, neg;
      longint dxq, dy, dx, res;
      longint unsigned p, d, q, r;
      ans = '0;
      if (it.op == OP_WRITE) begin
        bp_x[it.entry_index] = it.x_value;
        bp_y[it.entry_index] = it.y_value;
      end else begin
        n = (size_reg > DEPTH) ? DEPTH : size_reg;
        if (n < MIN_POINTS) begin
          ans.status = STATUS_SIZE_ERR;
        end else begin
          xq = it.x_value;
          rising = bp_x[n-1] >= bp_x[0];
          lo = 0;
          hi = n - 1;
          while (hi - lo > 1) begin
            mid = (hi + lo) >> 1;
            if ((xq >= bp_x[mid]) == rising) lo = mid;
            else hi = mid;
          end
          j = (lo > n - 2) ? n - 2 : lo;
          x0 = bp_x[j];
          x1 = bp_x[j+1];
          y0 = bp_y[j];
          y1 = bp_y[j+1];
          ans.segment = SEG_W'(j);
          if (mode_reg == MODE_STEP || x0 == x1) begin
            ans.y_result = y0;
          end else begin
            dxq = longint'(xq) - longint'(x0);
            dy  = longint'(y1) - longint'(y0);
            dx  = longint'(x1) - longint'(x0);
            neg = ((dxq < 0) != (dy < 0)) != (dx < 0);
            if (dxq == 0 || dy == 0) neg = 1'b0;
            p = magnitude(dxq) * magnitude(dy);
            d = magnitude(dx);
            q = p / d;
            r = p % d;
            // round half away from zero
            if (r >= d - r) q++;
            if (q > 64'h2_0000_0000) begin
              res = neg ? longint'(Y_MIN) : longint'(Y_MAX);
              ans.status = STATUS_SATURATED;
            end else begin
              res = longint'(y0) + (neg ? -longint'(q) : longint'(q));
              if (res > longint'(Y_MAX)) begin
                res = longint'(Y_MAX);
                ans.status = STATUS_SATURATED;
              end else if (res < longint'(Y_MIN)) begin
                res = longint'(Y_MIN);
                ans.status = STATUS_SATURATED;
              end
            end
            ans.y_result = res[31:0];
          end
        end
      end
      answers_due.push_back(ans);
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %h, got %h", $time, what, want, got);
    endfunction

    function void compare_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing pending: y %h segment %h status %h",
                   $time, got.y_result, got.segment, got.status);
      end else begin
        want = answers_due.pop_front();
        if (got.y_result !== want.y_result) flag("y_result", want.y_result, got.y_result);
        if (got.segment !== want.segment) flag("segment", want.segment, got.segment);
        if (got.status !== want.status) flag("status", want.status, got.status);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_data;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [PADDR_W-1:0]  cfg_paddr;
  logic [PDATA_W-1:0]  cfg_pwdata;
  logic [PDATA_W-1:0]  cfg_prdata;
  logic                cfg_pready;

  table_tracker sb;
  bit           loaded[DEPTH];
  bit           no_idle;
  bit           hold_long;
  int           sent_items;
  int           sent_queries;
  int           reg_writes;
  int           cfg_errors;

  table_interpolator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Called at a falling edge; returns at the falling edge after the beat, valid still high.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.accept_item(it);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic put_entry(input int idx, input logic [31:0] xv, input logic [31:0] yv);
    in_item_t it;
    it.op          = OP_WRITE;
    it.entry_index = IDX_W'(idx);
    it.x_value     = xv;
    it.y_value     = yv;
    loaded[idx]    = 1'b1;
    send_item(it);
  endtask

  task automatic ask(input logic [31:0] xv);
    in_item_t it;
    it.op          = OP_QUERY;
    it.entry_index = IDX_W'($urandom_range(0, 255));
    it.x_value     = xv;
    it.y_value     = $urandom;
    sent_queries++;
    send_item(it);
  endtask

  // Drop valid and hold until every answer has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.answers_due.size() != 0) @(negedge clk);
  endtask

  // Write a register, then read it back.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] want;
    want = (idx == REG_TABLE_SIZE) ? {23'b0, value[SIZE_W-1:0]} : {31'b0, value[0]};
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    sb.set_reg(idx, value);
    reg_writes++;
    @(negedge clk);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata !== want) begin
      cfg_errors++;
      $display("%0t: register %0d read back expected %h, got %h", $time, idx, want, cfg_prdata);
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // Fill entries 0..m-1 in shuffled order: rising, falling or unordered x.
  task automatic load_table(input int m);
    int xs[DEPTH];
    int ys[DEPTH];
    int slot[DEPTH];
    int shape, scale, yshape, i, k, tmp;
    longint xv, step;
    shape  = $urandom_range(0, 3);
    scale  = $urandom_range(0, 3);
    yshape = $urandom_range(0, 2);
    xv = longint'(int'($urandom)) >>> $urandom_range(0, 24);
    for (i = 0; i < m; i++) begin
      xs[i] = (xv > 2147483647) ? 32'h7FFF_FFFF : int'(xv);
      case (scale)
        0: step = $urandom_range(0, 3);
        1: step = $urandom_range(1, 'h3FF);
        2: step = $urandom_range('h400, 'h3FFFF);
        default: step = $urandom_range('h10000, 'hFFFFFF);
      endcase
      xv += step;
      if (shape == 3) xs[i] = int'($urandom) >>> $urandom_range(0, 16);
      case (yshape)
        0: ys[i] = int'($urandom);
        1: ys[i] = int'($urandom_range(0, 'h3FFFF)) - 'h20000;
        default: ys[i] = (i == 0) ? int'($urandom_range(0, 'hFFFF))
                                  : ys[i-1] + int'($urandom_range(0, 'h1FFFF)) - 'h10000;
      endcase
      slot[i] = i;
    end
    if (shape == 2) begin
      for (i = 0; i < m / 2; i++) begin
        tmp = xs[i];
        xs[i] = xs[m-1-i];
        xs[m-1-i] = tmp;
      end
    end
    for (i = m - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = slot[i];
      slot[i] = slot[k];
      slot[k] = tmp;
    end
    for (i = 0; i < m; i++) put_entry(slot[i], xs[slot[i]], ys[slot[i]]);
  endtask

  function automatic logic [31:0] pick_query_x(input int m);
    int k;
    longint span, v;
    if (m < 2) return $urandom;
    k = $urandom_range(0, m - 2);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return sb.bp_x[$urandom_range(0, m - 1)];
      2: return sb.bp_x[k] + int'($urandom_range(0, 8)) - 4;
      3: begin
        span = longint'(sb.bp_x[k+1]) - longint'(sb.bp_x[k]);
        v = longint'(sb.bp_x[k]) + span * longint'($urandom_range(0, 32)) / 32;
        return v[31:0];
      end
      4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return sb.bp_x[$urandom_range(0, 1) ? 0 : m - 1]
                      + int'($urandom_range(0, 'h3FFFF)) - 'h20000;
    endcase
  endfunction

  initial begin : result_sink
    int pause;
    bit holding;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      pause = no_idle ? 0 : $urandom_range(0, 7);
      holding = hold_long;
      if (holding) begin
        pause = HOLD_CYCLES;
        hold_long = 1'b0;
      end
      if (pause > 0) begin
        out_stall <= 1'b1;
        // a short stall counts only cycles with a beat on offer
        while (pause > 0) begin
          @(posedge clk);
          if (holding || out_valid === 1'b1) pause--;
        end
        @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.compare_result(out_data);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    wait (rst_n === 1'b1);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("%0t: no beat on either channel for %0d cycles", $time, idle);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int n, m, count, i, phase, goal;
    logic mode_sel;
    logic [31:0] junk;
    bit gaps_missing;
    sb = new;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    no_idle     = 1'b0;
    hold_long   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Registers at reset values: two points, linear.
    put_entry(0, 32'h8000_0000, 32'h8000_0000);
    put_entry(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    ask(32'h0000_0000);
    ask(32'h7FFF_FFFF);
    ask(32'h8000_0000);
    // halves round away from zero; outside the table extrapolate
    put_entry(0, 0, 0);
    put_entry(1, 2, 1);
    ask(1);
    ask(32'hFFFF_FFFF);
    ask(5);
    // steep segment saturates both ways
    put_entry(1, 1, 32'h7FFF_FFFF);
    ask(32'h7FFF_FFFF);
    ask(2);
    ask(32'hFFFF_FFFE);
    ask(32'h8000_0000);
    // coincident x holds the left y
    put_entry(1, 0, 5);
    ask(32'h0001_0000);
    put_entry(255, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    drain();
    write_reg(REG_TABLE_SIZE, 0);
    ask(7);
    drain();
    write_reg(REG_TABLE_SIZE, 1);
    ask(7);
    drain();
    write_reg(REG_TABLE_SIZE, 2);
    write_reg(REG_INTERP_MODE, MODE_STEP);
    put_entry(1, 2, 1);
    ask(1);
    ask(32'h8000_0000);
    drain();

    goal = sent_items + RANDOM_ITEMS;
    phase = 0;
    while (sent_items < goal) begin
      case (phase)
        0: n = DEPTH;
        1: n = 511;
        default: begin
          case ($urandom_range(0, 19))
            0: n = $urandom_range(0, 1);
            1: n = $urandom_range(0, 1) ? DEPTH : $urandom_range(DEPTH + 1, 511);
            2, 3: n = $urandom_range(17, DEPTH - 1);
            default: n = $urandom_range(2, 16);
          endcase
        end
      endcase
      mode_sel = ($urandom_range(0, 3) == 0) ? MODE_STEP : MODE_LINEAR;
      junk = ($urandom_range(0, 3) == 0) ? ($urandom & 32'hFFFF_FE00) : 32'h0;
      write_reg(REG_TABLE_SIZE, junk | n);
      write_reg(REG_INTERP_MODE, junk | mode_sel);
      no_idle = ($urandom_range(0, 4) == 0);
      m = (n > DEPTH) ? DEPTH : n;
      gaps_missing = 1'b0;
      for (i = 0; i < m; i++) if (!loaded[i]) gaps_missing = 1'b1;
      if (m >= MIN_POINTS && (gaps_missing || $urandom_range(0, 2) == 0)) load_table(m);
      // back up the output so the block fills and stalls its input
      if (phase == 3) hold_long = 1'b1;
      count = (m > 64) ? $urandom_range(6, 16) : $urandom_range(10, 40);
      repeat (count) begin
        if ($urandom_range(0, 7) == 0) begin
          if (m > 0 && $urandom_range(0, 1)) put_entry($urandom_range(0, m - 1), $urandom, $urandom);
          else put_entry($urandom_range(0, 255), $urandom, $urandom);
        end
        ask(pick_query_x(m));
      end
      drain();
      phase++;
    end

    repeat (120) @(negedge clk);
    $display("Covered %0d beats (%0d queries, %0d entry writes) over %0d phases, %0d reg writes;",
             sent_items, sent_queries, sent_items - sent_queries, phase, reg_writes);
    $display("compared %0d results: %0d mismatches, %0d register errors, %0d never arrived.",
             sb.results_seen, sb.mismatches, cfg_errors, sb.answers_due.size());
    if (sb.mismatches == 0 && cfg_errors == 0 && sb.answers_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
